FILE: rtl/nfpf_pkg.sv
// Package for the next pattern frame finder.
// Holds the parameter defaults, the configuration register layout and the
// flag struct that travels down the cell chain. No dependencies.
`default_nettype none

package nfpf_pkg;

   localparam int FIELD_BITS_DEF  = 32;
   localparam int CHUNK_BITS_DEF  = 4;
   localparam int CHUNK_COUNT_DEF = 8;

   localparam int CFG_WIDTH_BITS = 6;
   localparam logic [CFG_WIDTH_BITS-1:0] FIELD_WIDTH_RESET = 6'd32;

   // Result of the compare pass, handed from cell to cell.
   typedef struct packed {
      logic any_fixed;   // at least one fixed chunk lies inside the field
      logic diff;        // some fixed chunk differs from the point
      logic dir_up;      // the highest differing point chunk is above its value
   } scan_flags_type;

endpackage

`default_nettype wire

FILE: rtl/nfpf_scan_cell.sv
// Compare cell of the next pattern frame finder: one chunk of the pattern.
// Updates the running compare flags and indexes for its chunk and hands the
// item to the next cell. Depends on nfpf_pkg.
`default_nettype none

module nfpf_scan_cell #(
   parameter int CHUNK_BITS = nfpf_pkg::CHUNK_BITS_DEF,
   parameter int CHUNK_COUNT = nfpf_pkg::CHUNK_COUNT_DEF,
   parameter int INDEX = 0,
   localparam int PadW = CHUNK_COUNT * CHUNK_BITS,
   localparam int IdxW = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [PadW-1:0]         in_point,
   input  wire logic [CHUNK_COUNT-1:0]  in_mask,
   input  wire logic [PadW-1:0]         in_vals,
   input  wire nfpf_pkg::scan_flags_type in_flags,
   input  wire logic [IdxW-1:0]         in_diff_idx,
   input  wire logic [IdxW-1:0]         in_low_idx,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [PadW-1:0]              out_point,
   output logic [CHUNK_COUNT-1:0]       out_mask,
   output logic [PadW-1:0]              out_vals,
   output nfpf_pkg::scan_flags_type     out_flags,
   output logic [IdxW-1:0]              out_diff_idx,
   output logic [IdxW-1:0]              out_low_idx
);
   import nfpf_pkg::*;

   localparam logic [IdxW-1:0] KIdx = IdxW'(INDEX);

   logic                   valid_ff, valid_in;
   logic                   load;
   logic [PadW-1:0]        point_ff, vals_ff;
   logic [CHUNK_COUNT-1:0] mask_ff;
   scan_flags_type         flags_ff, flags_in;
   logic [IdxW-1:0]        diff_idx_ff, diff_idx_in;
   logic [IdxW-1:0]        low_idx_ff, low_idx_in;
   logic [CHUNK_BITS-1:0]  pc, vc;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign pc = in_point[INDEX*CHUNK_BITS +: CHUNK_BITS];
   assign vc = in_vals[INDEX*CHUNK_BITS +: CHUNK_BITS];

   // Cells run from the lowest chunk up, so a higher difference overrides a
   // lower one and the first fixed chunk seen is the lowest.
   always_comb begin
      flags_in    = in_flags;
      diff_idx_in = in_diff_idx;
      low_idx_in  = in_low_idx;
      if (in_mask[INDEX]) begin
         if (!in_flags.any_fixed) begin
            low_idx_in = KIdx;
         end
         flags_in.any_fixed = 1'b1;
         if (pc != vc) begin
            flags_in.diff   = 1'b1;
            flags_in.dir_up = (pc > vc);
            diff_idx_in     = KIdx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         point_ff    <= in_point;
         mask_ff     <= in_mask;
         vals_ff     <= in_vals;
         flags_ff    <= flags_in;
         diff_idx_ff <= diff_idx_in;
         low_idx_ff  <= low_idx_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_point    = point_ff;
   assign out_mask     = mask_ff;
   assign out_vals     = vals_ff;
   assign out_flags    = flags_ff;
   assign out_diff_idx = diff_idx_ff;
   assign out_low_idx  = low_idx_ff;

endmodule

`default_nettype wire

FILE: rtl/nfpf_build_cell.sv
// Build cell of the next pattern frame finder: one chunk of the result.
// Writes its chunk of the frame and passes the increment carry upward.
// Depends on nfpf_pkg.
`default_nettype none

module nfpf_build_cell #(
   parameter int CHUNK_BITS = nfpf_pkg::CHUNK_BITS_DEF,
   parameter int CHUNK_COUNT = nfpf_pkg::CHUNK_COUNT_DEF,
   parameter int INDEX = 0,
   localparam int PadW = CHUNK_COUNT * CHUNK_BITS,
   localparam int IdxW = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    active,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [PadW-1:0]         in_point,
   input  wire logic [CHUNK_COUNT-1:0]  in_mask,
   input  wire logic [PadW-1:0]         in_vals,
   input  wire nfpf_pkg::scan_flags_type in_flags,
   input  wire logic [IdxW-1:0]         in_diff_idx,
   input  wire logic [IdxW-1:0]         in_low_idx,
   input  wire logic [PadW-1:0]         in_frame,
   input  wire logic                    in_carry,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [PadW-1:0]              out_point,
   output logic [CHUNK_COUNT-1:0]       out_mask,
   output logic [PadW-1:0]              out_vals,
   output nfpf_pkg::scan_flags_type     out_flags,
   output logic [IdxW-1:0]              out_diff_idx,
   output logic [IdxW-1:0]              out_low_idx,
   output logic [PadW-1:0]              out_frame,
   output logic                         out_carry
);
   import nfpf_pkg::*;

   localparam logic [IdxW-1:0] KIdx = IdxW'(INDEX);

   logic                   valid_ff, valid_in;
   logic                   load;
   logic [PadW-1:0]        point_ff, vals_ff, frame_ff, frame_in;
   logic [CHUNK_COUNT-1:0] mask_ff;
   scan_flags_type         flags_ff;
   logic [IdxW-1:0]        diff_idx_ff, low_idx_ff;
   logic                   carry_ff, carry_in;
   logic [CHUNK_BITS-1:0]  pc, vc, fc;
   logic                   fixed;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign pc    = in_point[INDEX*CHUNK_BITS +: CHUNK_BITS];
   assign vc    = in_vals[INDEX*CHUNK_BITS +: CHUNK_BITS];
   assign fixed = in_mask[INDEX];

   always_comb begin
      fc       = '0;
      carry_in = in_carry;
      if (!in_flags.any_fixed) begin
         fc = '0;
      end else if (!in_flags.diff) begin
         // The point lies in a frame: clear everything below the lowest fixed chunk.
         fc = (KIdx < in_low_idx) ? '0 : pc;
      end else if (KIdx < in_diff_idx) begin
         fc = fixed ? vc : '0;
      end else if (KIdx == in_diff_idx) begin
         fc = vc;
      end else if (!active) begin
         // Chunks outside the field stay zero and let the carry run out the top.
         fc = '0;
      end else if (fixed) begin
         fc = pc;
      end else if (in_carry) begin
         if (pc == {CHUNK_BITS{1'b1}}) begin
            fc = '0;
         end else begin
            fc       = pc + 1'b1;
            carry_in = 1'b0;
         end
      end else begin
         fc = pc;
      end
   end

   always_comb begin
      frame_in = in_frame;
      frame_in[INDEX*CHUNK_BITS +: CHUNK_BITS] = fc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         point_ff    <= in_point;
         mask_ff     <= in_mask;
         vals_ff     <= in_vals;
         flags_ff    <= in_flags;
         diff_idx_ff <= in_diff_idx;
         low_idx_ff  <= in_low_idx;
         frame_ff    <= frame_in;
         carry_ff    <= carry_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_point    = point_ff;
   assign out_mask     = mask_ff;
   assign out_vals     = vals_ff;
   assign out_flags    = flags_ff;
   assign out_diff_idx = diff_idx_ff;
   assign out_low_idx  = low_idx_ff;
   assign out_frame    = frame_ff;
   assign out_carry    = carry_ff;

endmodule

`default_nettype wire

FILE: rtl/next_pattern_frame_finder.sv
// Next pattern frame finder: top level with the field width register.
// Instantiates the chains of nfpf_scan_cell and nfpf_build_cell; uses nfpf_pkg.
//
// Usage:
//   An item enters on the req_ channel (point, fixed chunk mask, fixed chunk
//   values) and leaves on the rsp_ channel (frame base, found), both valid and
//   ready. Each item first passes a row of CHUNK_COUNT compare cells, lowest
//   chunk first, then a row of CHUNK_COUNT build cells that write the frame one
//   chunk per cell and ripple the increment carry upward, then an output
//   register.
//   One item is accepted per cycle while rsp_ready holds; every cell is a
//   stage of its own, so throughput is one item per cycle when not stalled.
//   When the receiver stalls, items close up in the cells and input is still
//   taken until every stage is full; an item waiting at the output holds.
//   The csr_ channel writes the field width; it is always ready and should
//   be written only while no item is in flight.
//   Reset empties all stages and sets the field width to 32.
`default_nettype none

module next_pattern_frame_finder #(
   parameter int FIELD_BITS = nfpf_pkg::FIELD_BITS_DEF,
   parameter int CHUNK_BITS = nfpf_pkg::CHUNK_BITS_DEF,
   parameter int CHUNK_COUNT = nfpf_pkg::CHUNK_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [nfpf_pkg::CFG_WIDTH_BITS-1:0] csr_field_width,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [FIELD_BITS-1:0]               req_point,
   input  wire logic [CHUNK_COUNT-1:0]              req_fixed_chunk_mask,
   input  wire logic [FIELD_BITS-1:0]               req_fixed_chunk_values,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [FIELD_BITS-1:0]                    rsp_frame_base,
   output logic                                     rsp_found
);
   import nfpf_pkg::*;

   localparam int PadW = CHUNK_COUNT * CHUNK_BITS;
   localparam int IdxW = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;

   logic [CFG_WIDTH_BITS-1:0] field_width_ff;
   logic [CHUNK_COUNT-1:0]    active;
   logic [PadW-1:0]           act_bits;

   // Scan chain links, index 0 is the block input.
   logic                   s_valid    [CHUNK_COUNT+1];
   logic                   s_ready    [CHUNK_COUNT+1];
   logic [PadW-1:0]        s_point    [CHUNK_COUNT+1];
   logic [CHUNK_COUNT-1:0] s_mask     [CHUNK_COUNT+1];
   logic [PadW-1:0]        s_vals     [CHUNK_COUNT+1];
   scan_flags_type         s_flags    [CHUNK_COUNT+1];
   logic [IdxW-1:0]        s_diff_idx [CHUNK_COUNT+1];
   logic [IdxW-1:0]        s_low_idx  [CHUNK_COUNT+1];

   // Build chain links, index 0 is the end of the scan chain.
   logic                   b_valid    [CHUNK_COUNT+1];
   logic                   b_ready    [CHUNK_COUNT+1];
   logic [PadW-1:0]        b_point    [CHUNK_COUNT+1];
   logic [CHUNK_COUNT-1:0] b_mask     [CHUNK_COUNT+1];
   logic [PadW-1:0]        b_vals     [CHUNK_COUNT+1];
   scan_flags_type         b_flags    [CHUNK_COUNT+1];
   logic [IdxW-1:0]        b_diff_idx [CHUNK_COUNT+1];
   logic [IdxW-1:0]        b_low_idx  [CHUNK_COUNT+1];
   logic [PadW-1:0]        b_frame    [CHUNK_COUNT+1];
   logic                   b_carry    [CHUNK_COUNT+1];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [PadW-1:0]       rsp_frame_ff, rsp_frame_in;
   logic                  rsp_load;

   // Field width register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= FIELD_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         field_width_ff <= csr_field_width;
      end
   end

   // A chunk is in use when it fits both the programmed width and the field.
   for (genvar k = 0; k < CHUNK_COUNT; k++) begin : g_active
      localparam int Lim = (k + 1) * CHUNK_BITS;
      localparam bit Fits = (Lim <= FIELD_BITS);
      assign active[k] = Fits && (32'(field_width_ff) >= 32'(Lim));
      assign act_bits[k*CHUNK_BITS +: CHUNK_BITS] = {CHUNK_BITS{active[k]}};
   end

   // Chain input.
   assign s_valid[0]    = req_valid;
   assign req_ready     = s_ready[0];
   assign s_point[0]    = PadW'(req_point) & act_bits;
   assign s_mask[0]     = req_fixed_chunk_mask & active;
   assign s_vals[0]     = PadW'(req_fixed_chunk_values);
   assign s_flags[0]    = '0;
   assign s_diff_idx[0] = '0;
   assign s_low_idx[0]  = '0;

   for (genvar k = 0; k < CHUNK_COUNT; k++) begin : g_scan
      nfpf_scan_cell #(
         .CHUNK_BITS  (CHUNK_BITS),
         .CHUNK_COUNT (CHUNK_COUNT),
         .INDEX       (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (s_valid[k]),
         .in_ready     (s_ready[k]),
         .in_point     (s_point[k]),
         .in_mask      (s_mask[k]),
         .in_vals      (s_vals[k]),
         .in_flags     (s_flags[k]),
         .in_diff_idx  (s_diff_idx[k]),
         .in_low_idx   (s_low_idx[k]),
         .out_valid    (s_valid[k+1]),
         .out_ready    (s_ready[k+1]),
         .out_point    (s_point[k+1]),
         .out_mask     (s_mask[k+1]),
         .out_vals     (s_vals[k+1]),
         .out_flags    (s_flags[k+1]),
         .out_diff_idx (s_diff_idx[k+1]),
         .out_low_idx  (s_low_idx[k+1])
      );
   end

   // Hand over to the build chain; the carry starts when the point is above.
   assign b_valid[0]          = s_valid[CHUNK_COUNT];
   assign s_ready[CHUNK_COUNT] = b_ready[0];
   assign b_point[0]          = s_point[CHUNK_COUNT];
   assign b_mask[0]           = s_mask[CHUNK_COUNT];
   assign b_vals[0]           = s_vals[CHUNK_COUNT];
   assign b_flags[0]          = s_flags[CHUNK_COUNT];
   assign b_diff_idx[0]       = s_diff_idx[CHUNK_COUNT];
   assign b_low_idx[0]        = s_low_idx[CHUNK_COUNT];
   assign b_frame[0]          = '0;
   assign b_carry[0]          = s_flags[CHUNK_COUNT].diff && s_flags[CHUNK_COUNT].dir_up;

   for (genvar k = 0; k < CHUNK_COUNT; k++) begin : g_build
      nfpf_build_cell #(
         .CHUNK_BITS  (CHUNK_BITS),
         .CHUNK_COUNT (CHUNK_COUNT),
         .INDEX       (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .active       (active[k]),
         .in_valid     (b_valid[k]),
         .in_ready     (b_ready[k]),
         .in_point     (b_point[k]),
         .in_mask      (b_mask[k]),
         .in_vals      (b_vals[k]),
         .in_flags     (b_flags[k]),
         .in_diff_idx  (b_diff_idx[k]),
         .in_low_idx   (b_low_idx[k]),
         .in_frame     (b_frame[k]),
         .in_carry     (b_carry[k]),
         .out_valid    (b_valid[k+1]),
         .out_ready    (b_ready[k+1]),
         .out_point    (b_point[k+1]),
         .out_mask     (b_mask[k+1]),
         .out_vals     (b_vals[k+1]),
         .out_flags    (b_flags[k+1]),
         .out_diff_idx (b_diff_idx[k+1]),
         .out_low_idx  (b_low_idx[k+1]),
         .out_frame    (b_frame[k+1]),
         .out_carry    (b_carry[k+1])
      );
   end

   // Output register. A carry that leaves the top chunk means no frame exists.
   assign b_ready[CHUNK_COUNT] = !rsp_valid_ff || rsp_ready;
   assign rsp_load             = b_valid[CHUNK_COUNT] && b_ready[CHUNK_COUNT];
   assign rsp_valid_in         = b_ready[CHUNK_COUNT] ? b_valid[CHUNK_COUNT] : rsp_valid_ff;
   assign rsp_found_in         = !(b_flags[CHUNK_COUNT].any_fixed && b_flags[CHUNK_COUNT].diff
                                   && b_carry[CHUNK_COUNT]);
   assign rsp_frame_in         = rsp_found_in ? b_frame[CHUNK_COUNT] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= rsp_found_in;
         rsp_frame_ff <= rsp_frame_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_frame_base = FIELD_BITS'(rsp_frame_ff);

`ifndef SYNTHESIS
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_frame_base == '0)
      else $error("item without a frame carries a nonzero frame base");

   a_empty_no_diff: assert property (@(posedge clock) disable iff (reset)
      s_valid[CHUNK_COUNT] && !s_flags[CHUNK_COUNT].any_fixed |-> !s_flags[CHUNK_COUNT].diff)
      else $error("difference flagged for a pattern with no fixed chunk");

   a_output_fills: assert property (@(posedge clock) disable iff (reset)
      b_valid[CHUNK_COUNT] && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("finished item was not moved into the output register");

   a_empty_found: assert property (@(posedge clock) disable iff (reset)
      rsp_load && !b_flags[CHUNK_COUNT].any_fixed |=> rsp_found && rsp_frame_base == '0)
      else $error("empty pattern did not give frame zero");
`endif

endmodule

`default_nettype wire
